### rtl/core/gain_scheduled_position_pi_defines.svh
// assertion macros for the gain scheduled position pi controller
`ifndef GAIN_SCHEDULED_POSITION_PI_DEFINES_SVH
`define GAIN_SCHEDULED_POSITION_PI_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication, held off during reset
`define GSP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle check");

// next-cycle implication, held off during reset
`define GSP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle check");

`else

`define GSP_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define GSP_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

### rtl/core/gsp_pi_pkg.sv
// shared types and constants of the gain scheduled position pi controller
`timescale 1ns / 1ps
`default_nettype none

package gsp_pi_pkg;

    localparam int ERR_W    = 33;
    localparam int SUM_W    = 40;
    localparam int GAIN_W   = 16;
    localparam int LIM_W    = 31;
    localparam int OLIM_W   = 15;
    localparam int DRIVE_W  = 16;
    localparam int CFG_W    = 31;
    localparam int IDX_W    = 3;
    localparam int MUL_A_W  = 40;
    localparam int PROD_W   = MUL_A_W + GAIN_W;
    localparam int FRAC_W   = 20;

    // gain scale of about 0.7, as 179/256
    localparam logic [MUL_A_W-1:0] SCALE_NUM = MUL_A_W'(179);
    localparam int SCALE_SHIFT = 8;

    localparam logic [DRIVE_W-1:0] TERM_MAX = DRIVE_W'(32767);

    // register indexes
    typedef enum logic [IDX_W-1:0] {
        REG_PROP_GAIN  = 3'd0,
        REG_INT_GAIN   = 3'd1,
        REG_INT_WINDOW = 3'd2,
        REG_SUM_LIMIT  = 3'd3,
        REG_OUT_LIMIT  = 3'd4
    } reg_index_t;

    // reset values
    localparam logic [GAIN_W-1:0] PROP_GAIN_RST  = GAIN_W'(4800);
    localparam logic [GAIN_W-1:0] INT_GAIN_RST   = GAIN_W'(480);
    localparam logic [LIM_W-1:0]  INT_WINDOW_RST = LIM_W'(0);
    localparam logic [LIM_W-1:0]  SUM_LIMIT_RST  = LIM_W'(23757);
    localparam logic [OLIM_W-1:0] OUT_LIMIT_RST  = OLIM_W'(750);

endpackage

`default_nettype wire

### rtl/core/gain_scheduled_position_pi.sv
// gain scheduled position pi controller with conditional integration
`timescale 1ns / 1ps
`default_nettype none

`include "gain_scheduled_position_pi_defines.svh"

// Position PI controller. Each transfer on the input channel carries a target
// and a measured position (signed Q16.16) and yields exactly one drive value
// on the output channel. error = target - measured; when the error is below
// the previous sample's error both Q12.4 gains are scaled by 179/256. Inside
// the integration window (|error| < int_window) the error is added to the
// integral while the integral has not reached sum_limit in the error's
// direction; outside it the integral clears. drive = trunc(error*kp) +
// trunc(sum*ki), each term saturated to +/-32767, total clamped to
// +/-out_limit. An item passes through the idle step that takes the input
// transfer, then seven sequencer steps, with the result register loaded in
// the final step once the output is free. All four products (two
// gain scalings, two terms) go one after the other through a single 40x16
// multiplier, and the input stays stalled until the result is loaded. A
// finished result sits in the output register, so the next input can be
// taken while it waits; the sequencer holds in its final step only if the
// previous result has not yet been taken. Configuration writes through
// cfg_we/cfg_index/cfg_data take effect at once and are meant to happen
// while the block is idle.
module gain_scheduled_position_pi (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // configuration write port
    input  wire logic                              cfg_we,
    input  wire logic [gsp_pi_pkg::IDX_W-1:0]      cfg_index,
    input  wire logic [gsp_pi_pkg::CFG_W-1:0]      cfg_data,
    // input channel
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic signed [31:0]                target,
    input  wire logic signed [31:0]                measured,
    // output channel
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic signed [gsp_pi_pkg::DRIVE_W-1:0]  drive
);

    localparam int ERR_W   = gsp_pi_pkg::ERR_W;
    localparam int SUM_W   = gsp_pi_pkg::SUM_W;
    localparam int GAIN_W  = gsp_pi_pkg::GAIN_W;
    localparam int LIM_W   = gsp_pi_pkg::LIM_W;
    localparam int OLIM_W  = gsp_pi_pkg::OLIM_W;
    localparam int DRIVE_W = gsp_pi_pkg::DRIVE_W;
    localparam int MUL_A_W = gsp_pi_pkg::MUL_A_W;
    localparam int PROD_W  = gsp_pi_pkg::PROD_W;
    localparam int FRAC_W  = gsp_pi_pkg::FRAC_W;

    // sequencer steps
    typedef enum logic [2:0] {
        S_IDLE,     // waiting for an input transfer
        S_CMP,      // gain schedule and window compares
        S_ACC,      // integral update
        S_SCALE_P,  // multiplier: prop_gain * 179
        S_SCALE_I,  // multiplier: int_gain * 179
        S_TERM_P,   // multiplier: |error| * kp
        S_TERM_I,   // multiplier: |sum| * ki
        S_FIN       // sum the terms, clamp, load the result register
    } state_t;

    state_t state_reg, state_next;

    // configuration registers
    logic [GAIN_W-1:0] prop_gain_reg, prop_gain_next;
    logic [GAIN_W-1:0] int_gain_reg, int_gain_next;
    logic [LIM_W-1:0]  int_window_reg, int_window_next;
    logic [LIM_W-1:0]  sum_limit_reg, sum_limit_next;
    logic [OLIM_W-1:0] out_limit_reg, out_limit_next;

    // controller state
    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic signed [ERR_W-1:0] prev_err_reg, prev_err_next;

    // per-item working registers
    logic signed [ERR_W-1:0]   err_reg, err_next;
    logic                      scale_reg, scale_next;
    logic                      in_win_reg, in_win_next;
    logic [GAIN_W-1:0]         kp_reg, kp_next;
    logic [GAIN_W-1:0]         ki_reg, ki_next;
    logic [PROD_W-1:0]         prod_reg, prod_next;
    logic signed [DRIVE_W-1:0] tp_reg, tp_next;

    // result register
    logic                      out_valid_reg, out_valid_next;
    logic signed [DRIVE_W-1:0] drive_reg, drive_next;

    // shared multiplier
    logic [MUL_A_W-1:0] mul_a;
    logic [GAIN_W-1:0]  mul_b;
    logic [PROD_W-1:0]  mul_p;

    // helpers
    logic                      in_xfer;
    logic                      out_free;
    logic                      fin_wait;
    logic [ERR_W-1:0]          err_mag;
    logic [SUM_W-1:0]          sum_mag;
    logic signed [ERR_W:0]     err_w;
    logic signed [ERR_W:0]     win_w;
    logic signed [SUM_W-1:0]   slim_w;
    logic signed [SUM_W:0]     sum_add;
    logic [DRIVE_W-1:0]        term_q;
    logic signed [DRIVE_W-1:0] ti_val;
    logic signed [DRIVE_W:0]   total;
    logic signed [DRIVE_W:0]   olim_w;
    logic [GAIN_W-1:0]         scaled_gain;

    assign in_xfer   = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign fin_wait  = (state_reg == S_FIN) && out_valid_reg;
    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign drive     = drive_reg;

    // magnitudes fit unsigned in the same width (most negative included)
    assign err_mag = err_reg[ERR_W-1] ? ERR_W'(-err_reg) : ERR_W'(err_reg);
    assign sum_mag = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);

    assign err_w   = {err_reg[ERR_W-1], err_reg};
    assign win_w   = {{(ERR_W + 1 - LIM_W){1'b0}}, int_window_reg};
    assign slim_w  = {{(SUM_W - LIM_W){1'b0}}, sum_limit_reg};
    assign sum_add = {sum_reg[SUM_W-1], sum_reg}
                   + {{(SUM_W + 1 - ERR_W){err_reg[ERR_W-1]}}, err_reg};
    assign olim_w  = {{(DRIVE_W + 1 - OLIM_W){1'b0}}, out_limit_reg};

    // floor(gain * 179 / 256) from the previous product
    assign scaled_gain = prod_reg[gsp_pi_pkg::SCALE_SHIFT +: GAIN_W];

    // product of a term, shifted down to an integer and saturated
    assign term_q = (prod_reg[PROD_W-1:FRAC_W + DRIVE_W - 1] != '0)
                  ? gsp_pi_pkg::TERM_MAX
                  : {1'b0, prod_reg[FRAC_W +: DRIVE_W - 1]};

    // integral term, signed by the updated integral (valid in the final step)
    assign ti_val = sum_reg[SUM_W-1] ? -$signed(term_q) : $signed(term_q);

    assign total = {tp_reg[DRIVE_W-1], tp_reg} + {ti_val[DRIVE_W-1], ti_val};

    // operand selection for the shared multiplier
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_SCALE_P:
            begin
                mul_a = gsp_pi_pkg::SCALE_NUM;
                mul_b = prop_gain_reg;
            end
            S_SCALE_I:
            begin
                mul_a = gsp_pi_pkg::SCALE_NUM;
                mul_b = int_gain_reg;
            end
            S_TERM_P:
            begin
                mul_a = {{(MUL_A_W - ERR_W){1'b0}}, err_mag};
                mul_b = kp_reg;
            end
            S_TERM_I:
            begin
                mul_a = sum_mag;
                mul_b = ki_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = {{GAIN_W{1'b0}}, mul_a} * {{MUL_A_W{1'b0}}, mul_b};

    always_comb
    begin
        state_next      = state_reg;
        prop_gain_next  = prop_gain_reg;
        int_gain_next   = int_gain_reg;
        int_window_next = int_window_reg;
        sum_limit_next  = sum_limit_reg;
        out_limit_next  = out_limit_reg;
        sum_next        = sum_reg;
        prev_err_next   = prev_err_reg;
        err_next        = err_reg;
        scale_next      = scale_reg;
        in_win_next     = in_win_reg;
        kp_next         = kp_reg;
        ki_next         = ki_reg;
        prod_next       = prod_reg;
        tp_next         = tp_reg;
        out_valid_next  = out_valid_reg;
        drive_next      = drive_reg;

        // result taken downstream
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        // register writes
        if (cfg_we)
        begin
            case (cfg_index)
                gsp_pi_pkg::REG_PROP_GAIN:  prop_gain_next  = cfg_data[GAIN_W-1:0];
                gsp_pi_pkg::REG_INT_GAIN:   int_gain_next   = cfg_data[GAIN_W-1:0];
                gsp_pi_pkg::REG_INT_WINDOW: int_window_next = cfg_data[LIM_W-1:0];
                gsp_pi_pkg::REG_SUM_LIMIT:  sum_limit_next  = cfg_data[LIM_W-1:0];
                gsp_pi_pkg::REG_OUT_LIMIT:  out_limit_next  = cfg_data[OLIM_W-1:0];
                default: ;
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    err_next   = {target[31], target} - {measured[31], measured};
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                scale_next    = (err_reg < prev_err_reg);
                prev_err_next = err_reg;
                in_win_next   = (err_w > -win_w) && (err_w < win_w);
                state_next    = S_ACC;
            end
            S_ACC:
            begin
                if (!in_win_reg)
                begin
                    sum_next = '0;
                end
                else if ((!err_reg[ERR_W-1] && (err_reg != '0) && (sum_reg < slim_w))
                      || (err_reg[ERR_W-1] && (sum_reg > -slim_w)))
                begin
                    // saturate at the 40-bit signed range
                    if (sum_add[SUM_W] != sum_add[SUM_W-1])
                    begin
                        sum_next = sum_add[SUM_W]
                                 ? {1'b1, {(SUM_W - 1){1'b0}}}
                                 : {1'b0, {(SUM_W - 1){1'b1}}};
                    end
                    else
                    begin
                        sum_next = sum_add[SUM_W-1:0];
                    end
                end
                state_next = S_SCALE_P;
            end
            S_SCALE_P:
            begin
                prod_next  = mul_p;
                state_next = S_SCALE_I;
            end
            S_SCALE_I:
            begin
                kp_next    = scale_reg ? scaled_gain : prop_gain_reg;
                prod_next  = mul_p;
                state_next = S_TERM_P;
            end
            S_TERM_P:
            begin
                ki_next    = scale_reg ? scaled_gain : int_gain_reg;
                prod_next  = mul_p;
                state_next = S_TERM_I;
            end
            S_TERM_I:
            begin
                tp_next    = err_reg[ERR_W-1] ? -$signed(term_q) : $signed(term_q);
                prod_next  = mul_p;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                // wait here while the previous result is still pending
                if (out_free)
                begin
                    if (total > olim_w)
                    begin
                        drive_next = DRIVE_W'(olim_w);
                    end
                    else if (total < -olim_w)
                    begin
                        drive_next = DRIVE_W'(-olim_w);
                    end
                    else
                    begin
                        drive_next = DRIVE_W'(total);
                    end
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            prop_gain_reg  <= gsp_pi_pkg::PROP_GAIN_RST;
            int_gain_reg   <= gsp_pi_pkg::INT_GAIN_RST;
            int_window_reg <= gsp_pi_pkg::INT_WINDOW_RST;
            sum_limit_reg  <= gsp_pi_pkg::SUM_LIMIT_RST;
            out_limit_reg  <= gsp_pi_pkg::OUT_LIMIT_RST;
            sum_reg        <= '0;
            prev_err_reg   <= '0;
            err_reg        <= '0;
            scale_reg      <= 1'b0;
            in_win_reg     <= 1'b0;
            kp_reg         <= '0;
            ki_reg         <= '0;
            prod_reg       <= '0;
            tp_reg         <= '0;
            out_valid_reg  <= 1'b0;
            drive_reg      <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            prop_gain_reg  <= prop_gain_next;
            int_gain_reg   <= int_gain_next;
            int_window_reg <= int_window_next;
            sum_limit_reg  <= sum_limit_next;
            out_limit_reg  <= out_limit_next;
            sum_reg        <= sum_next;
            prev_err_reg   <= prev_err_next;
            err_reg        <= err_next;
            scale_reg      <= scale_next;
            in_win_reg     <= in_win_next;
            kp_reg         <= kp_next;
            ki_reg         <= ki_next;
            prod_reg       <= prod_next;
            tp_reg         <= tp_next;
            out_valid_reg  <= out_valid_next;
            drive_reg      <= drive_next;
        end
    end

    // an input transfer starts the sequence
    `GSP_ASSERT_NEXT(a_start_seq, clk, rst_n, in_xfer, state_reg == S_CMP)

    // a finished item does not leave while the previous result is still pending
    `GSP_ASSERT_NEXT(a_fin_hold, clk, rst_n, fin_wait && out_stall, fin_wait)

    // the input is stalled whenever the sequencer is busy
    `GSP_ASSERT_NOW(a_busy_stall, clk, rst_n, state_reg != S_IDLE, in_stall)

endmodule

`default_nettype wire

### sim/drive_checker.sv
// drive checker for the gain scheduled position pi controller
`timescale 1ns / 1ps

module drive_checker (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [gsp_pi_pkg::IDX_W-1:0]          cfg_index,
    input  logic [gsp_pi_pkg::CFG_W-1:0]          cfg_data,
    input  logic                                  in_valid,
    input  logic                                  in_stall,
    input  logic signed [31:0]                    target,
    input  logic signed [31:0]                    measured,
    input  logic                                  out_valid,
    input  logic                                  out_stall,
    input  logic signed [gsp_pi_pkg::DRIVE_W-1:0] drive,
    output int                                    error_count,
    output int                                    drives_owed
);

    localparam int ERR_W   = gsp_pi_pkg::ERR_W;
    localparam int SUM_W   = gsp_pi_pkg::SUM_W;
    localparam int GAIN_W  = gsp_pi_pkg::GAIN_W;
    localparam int LIM_W   = gsp_pi_pkg::LIM_W;
    localparam int OLIM_W  = gsp_pi_pkg::OLIM_W;
    localparam int DRIVE_W = gsp_pi_pkg::DRIVE_W;
    localparam int FRAC_W  = gsp_pi_pkg::FRAC_W;

    typedef struct packed {
        logic [GAIN_W-1:0] prop_gain;
        logic [GAIN_W-1:0] int_gain;
        logic [LIM_W-1:0]  int_window;
        logic [LIM_W-1:0]  sum_limit;
        logic [OLIM_W-1:0] out_limit;
    } pi_settings_t;

    localparam longint SUM_HI = (longint'(1) <<< (SUM_W - 1)) - 1;
    localparam longint SUM_LO = -SUM_HI - 1;

    pi_settings_t              settings;
    logic signed [SUM_W-1:0]   integral;
    logic signed [ERR_W-1:0]   last_error;
    logic signed [DRIVE_W-1:0] expected_drive[$];

    // product with 20 fraction bits, truncated toward zero, saturated
    function automatic longint gain_term(longint v, longint g);
        longint mag;
        longint q;
        mag = (v < 0) ? -v : v;
        q = (mag * g) >>> FRAC_W;
        if (q > longint'(gsp_pi_pkg::TERM_MAX))
            q = longint'(gsp_pi_pkg::TERM_MAX);
        return (v < 0) ? -q : q;
    endfunction

    // one control sample: updates integral and last error, returns the drive
    function automatic logic signed [DRIVE_W-1:0] control_step(logic signed [31:0] tgt,
                                                              logic signed [31:0] meas);
        longint err;
        longint kp;
        longint ki;
        longint sum;
        longint win;
        longint slim;
        longint olim;
        longint total;
        err  = longint'(tgt) - longint'(meas);
        kp   = longint'(settings.prop_gain);
        ki   = longint'(settings.int_gain);
        win  = longint'(settings.int_window);
        slim = longint'(settings.sum_limit);
        olim = longint'(settings.out_limit);
        sum  = longint'(integral);
        if (err < longint'(last_error))
        begin
            kp = (kp * longint'(gsp_pi_pkg::SCALE_NUM)) >>> gsp_pi_pkg::SCALE_SHIFT;
            ki = (ki * longint'(gsp_pi_pkg::SCALE_NUM)) >>> gsp_pi_pkg::SCALE_SHIFT;
        end
        last_error = err[ERR_W-1:0];
        if (err > -win && err < win)
        begin
            if ((err > 0 && sum < slim) || (err < 0 && sum > -slim))
            begin
                sum = sum + err;
                if (sum > SUM_HI)
                    sum = SUM_HI;
                else if (sum < SUM_LO)
                    sum = SUM_LO;
            end
        end
        else
        begin
            sum = 0;
        end
        integral = sum[SUM_W-1:0];
        total = gain_term(err, kp) + gain_term(sum, ki);
        if (total > olim)
            total = olim;
        else if (total < -olim)
            total = -olim;
        return total[DRIVE_W-1:0];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        logic signed [DRIVE_W-1:0] want;
        if (!rst_n)
        begin
            settings.prop_gain  = gsp_pi_pkg::PROP_GAIN_RST;
            settings.int_gain   = gsp_pi_pkg::INT_GAIN_RST;
            settings.int_window = gsp_pi_pkg::INT_WINDOW_RST;
            settings.sum_limit  = gsp_pi_pkg::SUM_LIMIT_RST;
            settings.out_limit  = gsp_pi_pkg::OUT_LIMIT_RST;
            integral    = '0;
            last_error  = '0;
            error_count = 0;
            expected_drive.delete();
        end
        else
        begin
            // result side first, so a stray result cannot match a fresh item
            if (out_valid && !out_stall)
            begin
                if (expected_drive.size() == 0)
                begin
                    $error("drive transfer with nothing expected, got %0d", drive);
                    error_count++;
                end
                else
                begin
                    want = expected_drive.pop_front();
                    if (drive !== want)
                    begin
                        $error("drive mismatch: expected %0d, got %0d", want, drive);
                        error_count++;
                    end
                end
            end
            if (in_valid && !in_stall)
                expected_drive.push_back(control_step(target, measured));
            if (cfg_we)
            begin
                case (cfg_index)
                    gsp_pi_pkg::REG_PROP_GAIN:  settings.prop_gain  = cfg_data[GAIN_W-1:0];
                    gsp_pi_pkg::REG_INT_GAIN:   settings.int_gain   = cfg_data[GAIN_W-1:0];
                    gsp_pi_pkg::REG_INT_WINDOW: settings.int_window = cfg_data[LIM_W-1:0];
                    gsp_pi_pkg::REG_SUM_LIMIT:  settings.sum_limit  = cfg_data[LIM_W-1:0];
                    gsp_pi_pkg::REG_OUT_LIMIT:  settings.out_limit  = cfg_data[OLIM_W-1:0];
                    default: ;
                endcase
            end
        end
        drives_owed = expected_drive.size();
    end

endmodule

### sim/tb_top.sv
// testbench top for the gain scheduled position pi controller
`timescale 1ns / 1ps

module tb_top;

    localparam int GAIN_W  = gsp_pi_pkg::GAIN_W;
    localparam int LIM_W   = gsp_pi_pkg::LIM_W;
    localparam int OLIM_W  = gsp_pi_pkg::OLIM_W;
    localparam int IDX_W   = gsp_pi_pkg::IDX_W;
    localparam int CFG_W   = gsp_pi_pkg::CFG_W;
    localparam int DRIVE_W = gsp_pi_pkg::DRIVE_W;

    // block latency from input transfer to result register
    localparam int LATENCY     = 7;
    // long receiver hold-off used to back the block up
    localparam int HOLD_CYCLES = 300;
    localparam int PHASE_ITEMS = 230;
    localparam int NUM_PHASES  = 8;

    typedef struct packed {
        logic [GAIN_W-1:0] prop_gain;
        logic [GAIN_W-1:0] int_gain;
        logic [LIM_W-1:0]  int_window;
        logic [LIM_W-1:0]  sum_limit;
        logic [OLIM_W-1:0] out_limit;
    } pi_settings_t;

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      cfg_we;
    logic [IDX_W-1:0]          cfg_index;
    logic [CFG_W-1:0]          cfg_data;
    logic                      in_valid;
    logic                      in_stall;
    logic signed [31:0]        target;
    logic signed [31:0]        measured;
    logic                      out_valid;
    logic                      out_stall;
    logic signed [DRIVE_W-1:0] drive;

    int error_count;
    int drives_owed;

    // stimulus knobs shared with the receiver process
    logic             quiet;
    logic             hold_req;
    logic [LIM_W-1:0] cur_window;

    gain_scheduled_position_pi dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .target    (target),
        .measured  (measured),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .drive     (drive)
    );

    drive_checker drv_chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .target      (target),
        .measured    (measured),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .drive       (drive),
        .error_count (error_count),
        .drives_owed (drives_owed)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // overall time limit, far above the slowest legal run
    initial
    begin
        #(5_000_000);
        $display("simulation failed");
        $finish;
    end

    // result side: random stalls, a quiet stretch, and one long hold-off
    initial
    begin
        out_stall = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                // keep stalling while the sender keeps offering items
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                out_stall <= 1'b0;
                hold_req = 1'b0;
            end
            else if (quiet)
                out_stall <= 1'b0;
            else
                out_stall <= ($urandom_range(99, 0) < 28);
        end
    end

    // one register write per edge, write enable left high for the next one
    task automatic put_reg(input gsp_pi_pkg::reg_index_t idx, input logic [CFG_W-1:0] value);
        begin
            cfg_we    <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= value;
            @(posedge clk);
        end
    endtask

    // writes all five registers, only called with the block idle
    task automatic apply_settings(input pi_settings_t s);
        begin
            put_reg(gsp_pi_pkg::REG_PROP_GAIN,  CFG_W'(s.prop_gain));
            put_reg(gsp_pi_pkg::REG_INT_GAIN,   CFG_W'(s.int_gain));
            put_reg(gsp_pi_pkg::REG_INT_WINDOW, CFG_W'(s.int_window));
            put_reg(gsp_pi_pkg::REG_SUM_LIMIT,  CFG_W'(s.sum_limit));
            put_reg(gsp_pi_pkg::REG_OUT_LIMIT,  CFG_W'(s.out_limit));
            cfg_we     <= 1'b0;
            cur_window = s.int_window;
        end
    endtask

    function automatic pi_settings_t random_settings();
        pi_settings_t s;
        s.prop_gain  = GAIN_W'($urandom_range(65535, 0));
        s.int_gain   = GAIN_W'($urandom_range(65535, 0));
        s.int_window = LIM_W'($urandom() >> $urandom_range(16, 1));
        s.sum_limit  = LIM_W'($urandom() >> $urandom_range(16, 1));
        s.out_limit  = OLIM_W'($urandom_range(32767, 0));
        return s;
    endfunction

    // offer one item and hold it until the transfer happens
    task automatic send_item(input logic signed [31:0] tgt, input logic signed [31:0] meas);
        begin
            // random gap so idle cycles land on every step of the sequence
            if (!quiet && $urandom_range(99, 0) < 30)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(14, 1)) @(posedge clk);
            end
            in_valid <= 1'b1;
            target   <= tgt;
            measured <= meas;
            @(posedge clk);
            while (in_stall) @(posedge clk);
        end
    endtask

    function automatic logic signed [31:0] edge_position();
        case ($urandom_range(4, 0))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7FFF_FFFF;
            2:       return 32'sh0000_0000;
            3:       return 32'shFFFF_FFFF;
            default: return $urandom();
        endcase
    endfunction

    // mostly errors inside or on the window so the integral gets exercised,
    // the rest edge positions and raw noise
    task automatic send_random();
        logic signed [31:0] tgt;
        logic signed [31:0] meas;
        longint             span;
        longint             err;
        int                 pick;
        begin
            pick = $urandom_range(99, 0);
            meas = $urandom();
            tgt  = $urandom();
            err  = 0;
            if (cur_window != '0)
                span = longint'(cur_window);
            else
                span = longint'(1) <<< $urandom_range(24, 4);
            if (pick < 60)
            begin
                err = longint'($urandom_range(32'(span), 0));
                if ($urandom_range(3, 0) == 0)
                    err = err >>> $urandom_range(24, 0);
            end
            else if (pick < 75)
                err = span - longint'($urandom_range(1, 0));
            if ($urandom_range(1, 0) == 1)
                err = -err;
            if (pick < 75)
                tgt = meas + err[31:0];
            else if (pick < 85)
            begin
                tgt  = edge_position();
                meas = edge_position();
            end
            send_item(tgt, meas);
        end
    endtask

    // drop valid, wait for every owed drive, then let the pipeline settle
    task automatic finish_phase();
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while (drives_owed != 0) @(posedge clk);
            repeat (LATENCY + 4) @(posedge clk);
        end
    endtask

    initial
    begin : stimulus
        pi_settings_t s;
        rst_n      = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        in_valid   = 1'b0;
        target     = '0;
        measured   = '0;
        quiet      = 1'b0;
        hold_req   = 1'b0;
        cur_window = gsp_pi_pkg::INT_WINDOW_RST;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: window of 16.0, no output clamp so both terms show
        s = '{prop_gain: 16'd4800, int_gain: 16'd480, int_window: 31'h0010_0000,
              sum_limit: 31'd23757, out_limit: 15'd32767};
        apply_settings(s);
        send_item(32'sh0000_0000, 32'sh0000_0000);   // zero error keeps integral
        send_item(32'sh0001_0000, 32'sh0000_0000);   // +1.0, integrates
        send_item(32'sh0001_0000, 32'sh0000_0000);   // equal error, no gain scaling
        send_item(32'sh0000_0000, 32'sh0001_0000);   // falling error scales gains
        send_item(32'sh0000_4E20, 32'sh0000_0000);
        send_item(32'sh0000_4E20, 32'sh0000_0000);   // overshoots sum limit by one step
        send_item(32'sh0000_4E20, 32'sh0000_0000);   // held at the limit
        send_item(32'sh0010_0000, 32'sh0000_0000);   // error on window edge clears
        send_item(32'sh000F_FFFF, 32'sh0000_0000);   // just inside window
        send_item(32'sh0000_0000, 32'sh0010_0000);   // negative window edge clears
        send_item(32'sh0000_0000, 32'sh000F_FFFF);
        send_item(32'sh7FFF_FFFF, 32'sh8000_0000);   // largest positive error
        send_item(32'sh8000_0000, 32'sh7FFF_FFFF);   // largest negative error
        send_item(32'sh8000_0000, 32'sh8000_0000);
        send_item(32'sh7FFF_FFFF, 32'shFFFF_FFFF);
        send_item(32'shFFFF_FFFF, 32'sh0000_0001);
        send_item(32'sh5555_5555, 32'shAAAA_AAAA);
        finish_phase();

        // directed: reset values, zero window and the 750 clamp
        s = '{prop_gain: gsp_pi_pkg::PROP_GAIN_RST,
              int_gain: gsp_pi_pkg::INT_GAIN_RST,
              int_window: gsp_pi_pkg::INT_WINDOW_RST,
              sum_limit: gsp_pi_pkg::SUM_LIMIT_RST,
              out_limit: gsp_pi_pkg::OUT_LIMIT_RST};
        apply_settings(s);
        send_item(32'sh000A_0000, 32'sh0000_0000);
        send_item(32'sh0000_0000, 32'sh000A_0000);
        finish_phase();

        // directed: zero output limit forces zero drive
        s = '{prop_gain: 16'hFFFF, int_gain: 16'hFFFF, int_window: 31'h7FFF_FFFF,
              sum_limit: 31'h7FFF_FFFF, out_limit: 15'd0};
        apply_settings(s);
        send_item(32'sh0001_0000, 32'sh0000_0000);
        send_item(32'sh0000_0000, 32'sh0100_0000);
        finish_phase();

        // random phases across a spread of register settings
        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            case (phase)
                0: s = '{prop_gain: gsp_pi_pkg::PROP_GAIN_RST,
                         int_gain: gsp_pi_pkg::INT_GAIN_RST,
                         int_window: 31'h0004_0000,
                         sum_limit: gsp_pi_pkg::SUM_LIMIT_RST,
                         out_limit: gsp_pi_pkg::OUT_LIMIT_RST};
                1: s = '{prop_gain: 16'hFFFF, int_gain: 16'hFFFF, int_window: 31'h7FFF_FFFF,
                         sum_limit: 31'h7FFF_FFFF, out_limit: 15'h7FFF};
                2: s = '0;
                4: s = '{prop_gain: 16'd16, int_gain: 16'd16, int_window: 31'h7FFF_FFFF,
                         sum_limit: 31'd1000, out_limit: 15'h7FFF};
                6: s = '{prop_gain: 16'hFFFF, int_gain: 16'hFFFF, int_window: 31'h0001_0000,
                         sum_limit: 31'd0, out_limit: 15'd1};
                default: s = random_settings();
            endcase
            apply_settings(s);
            // one stretch with no idling on either side
            quiet = (phase == 3);
            // one phase starts with the receiver held off
            if (phase == 5)
                hold_req = 1'b1;
            repeat (PHASE_ITEMS) send_random();
            finish_phase();
        end

        if (error_count == 0 && drives_owed == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
